@@ rtl/dtq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtq_pkg
// Shared types and constants of the drop-tail packet descriptor queue.
// ----------------------------------------------------------------------------
package dtq_pkg;

   localparam int QUEUE_DEPTH = 128;
   localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS    = 8;
   localparam int SIZE_BITS   = 16;
   localparam int HANDLE_BITS = 16;
   localparam int BYTES_BITS  = 23;
   localparam int ADDR_BITS   = 4;
   localparam int DATA_BITS   = 32;

   localparam logic [CNT_BITS-1:0]   RESET_MAX_PACKETS = CNT_BITS'(100);
   localparam logic [BYTES_BITS-1:0] RESET_MAX_BYTES   = BYTES_BITS'(100 * 65535);
   localparam logic [CNT_BITS-1:0]   DEPTH_COUNT       = CNT_BITS'(QUEUE_DEPTH);
   localparam logic [PTR_BITS-1:0]   LAST_SLOT         = PTR_BITS'(QUEUE_DEPTH - 1);

   // operation codes; the unused code reads like a peek
   localparam logic [1:0] OP_ENQUEUE = 2'd0;
   localparam logic [1:0] OP_DEQUEUE = 2'd1;
   localparam logic [1:0] OP_PEEK    = 2'd2;

   localparam logic [1:0] STATUS_ENQUEUED  = 2'd0;
   localparam logic [1:0] STATUS_DROPPED   = 2'd1;
   localparam logic [1:0] STATUS_DELIVERED = 2'd2;
   localparam logic [1:0] STATUS_EMPTY     = 2'd3;

   // register indexes (byte address / 4)
   localparam logic [1:0] REG_LIMIT_MODE  = 2'd0;
   localparam logic [1:0] REG_MAX_PACKETS = 2'd1;
   localparam logic [1:0] REG_MAX_BYTES   = 2'd2;

   typedef struct packed {
      logic [1:0]             opcode;
      logic [HANDLE_BITS-1:0] packet_handle;
      logic [SIZE_BITS-1:0]   packet_size;
   } req_type;

   typedef struct packed {
      logic [1:0]             status;
      logic [HANDLE_BITS-1:0] head_handle;
      logic [SIZE_BITS-1:0]   head_size;
      logic [CNT_BITS-1:0]    packets_held;
      logic [BYTES_BITS-1:0]  bytes_held;
   } rsp_type;

   typedef struct packed {
      logic                  limit_mode;
      logic [CNT_BITS-1:0]   max_packets;
      logic [BYTES_BITS-1:0] max_bytes;
   } cfg_type;

   typedef struct packed {
      logic [HANDLE_BITS-1:0] handle;
      logic [SIZE_BITS-1:0]   size;
   } entry_type;

   // controller to datapath
   typedef struct packed {
      logic load;   // capture request, read head slot
      logic exec;   // resolve operation, update queue, launch result
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } ctrl_state_type;

endpackage

@@ rtl/dtq_csr.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtq_csr
// APB-style register file holding the admission limits.
// ----------------------------------------------------------------------------
module dtq_csr
   import dtq_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [ADDR_BITS-1:0] paddr,
   input  logic [DATA_BITS-1:0] pwdata,
   output logic [DATA_BITS-1:0] prdata,
   output logic                 pready,
   output cfg_type              cfg
);

   logic                  limit_mode_ff,  limit_mode_in;
   logic [CNT_BITS-1:0]   max_packets_ff, max_packets_in;
   logic [BYTES_BITS-1:0] max_bytes_ff,   max_bytes_in;
   logic                  wr_en;
   logic [1:0]            reg_index;

   assign pready    = 1'b1;
   assign wr_en     = psel & penable & pwrite & pready;
   assign reg_index = paddr[3:2];

   always_comb begin
      limit_mode_in  = limit_mode_ff;
      max_packets_in = max_packets_ff;
      max_bytes_in   = max_bytes_ff;
      if (wr_en) begin
         case (reg_index)
            REG_LIMIT_MODE:  limit_mode_in  = pwdata[0];
            REG_MAX_PACKETS: max_packets_in = pwdata[CNT_BITS-1:0];
            REG_MAX_BYTES:   max_bytes_in   = pwdata[BYTES_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_mode_ff  <= 1'b0;
         max_packets_ff <= RESET_MAX_PACKETS;
         max_bytes_ff   <= RESET_MAX_BYTES;
      end else begin
         limit_mode_ff  <= limit_mode_in;
         max_packets_ff <= max_packets_in;
         max_bytes_ff   <= max_bytes_in;
      end
   end

   always_comb begin
      case (reg_index)
         REG_LIMIT_MODE:  prdata = {{(DATA_BITS-1){1'b0}}, limit_mode_ff};
         REG_MAX_PACKETS: prdata = {{(DATA_BITS-CNT_BITS){1'b0}}, max_packets_ff};
         REG_MAX_BYTES:   prdata = {{(DATA_BITS-BYTES_BITS){1'b0}}, max_bytes_ff};
         default:         prdata = '0;
      endcase
   end

   assign cfg.limit_mode  = limit_mode_ff;
   assign cfg.max_packets = max_packets_ff;
   assign cfg.max_bytes   = max_bytes_ff;

endmodule

@@ rtl/dtq_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtq_ctrl
// Two-state sequencer: accept a request, then resolve it against the queue.
// ----------------------------------------------------------------------------
module dtq_ctrl
   import dtq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   output cmd_type cmd
);

   ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_EXEC;
         end
         ST_EXEC: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy     = (state_ff != ST_IDLE);
   assign cmd.load = start & ~busy;
   assign cmd.exec = (state_ff == ST_EXEC);

`ifndef SYNTHESIS
   a_exec_one_cycle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EXEC |=> state_ff == ST_IDLE)
      else $error("exec state held longer than one cycle");

   a_exec_follows_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> cmd.exec)
      else $error("accepted beat not executed");

   a_no_load_when_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |-> !cmd.load)
      else $error("load issued during exec");
`endif

endmodule

@@ rtl/dtq_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtq_datapath
// Descriptor memory, ring pointers, occupancy counters and result register.
// ----------------------------------------------------------------------------
module dtq_datapath
   import dtq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cmd_type cmd,
   input  cfg_type cfg,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   entry_type             store_ff [QUEUE_DEPTH];
   entry_type             head_entry_ff;
   req_type               req_ff;
   logic [PTR_BITS-1:0]   head_ff,  head_in;
   logic [PTR_BITS-1:0]   tail_ff,  tail_in;
   logic [CNT_BITS-1:0]   cnt_ff,   cnt_in;
   logic [BYTES_BITS-1:0] bytes_ff, bytes_in;
   logic                  rsp_valid_ff;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic                  is_enq, is_deq, empty, drop, do_write;
   logic [BYTES_BITS:0]   byte_sum;

   // descriptor memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (do_write) store_ff[tail_ff] <= {req_ff.packet_handle, req_ff.packet_size};
      if (cmd.load) head_entry_ff <= store_ff[head_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req_data;
   end

   assign is_enq   = (req_ff.opcode == OP_ENQUEUE);
   assign is_deq   = (req_ff.opcode == OP_DEQUEUE);
   assign empty    = (cnt_ff == '0);
   assign byte_sum = {1'b0, bytes_ff} + (BYTES_BITS+1)'(req_ff.packet_size);

   always_comb begin
      drop = (cnt_ff >= DEPTH_COUNT);
      if (!cfg.limit_mode && (cnt_ff >= cfg.max_packets)) drop = 1'b1;
      if (cfg.limit_mode && (byte_sum >= {1'b0, cfg.max_bytes})) drop = 1'b1;
   end

   assign do_write = cmd.exec & is_enq & ~drop;

   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      cnt_in      = cnt_ff;
      bytes_in    = bytes_ff;
      rsp_data_in = rsp_data_ff;
      if (cmd.exec) begin
         rsp_data_in.head_handle = '0;
         rsp_data_in.head_size   = '0;
         if (is_enq) begin
            if (drop) begin
               rsp_data_in.status = STATUS_DROPPED;
            end else begin
               rsp_data_in.status = STATUS_ENQUEUED;
               tail_in  = (tail_ff == LAST_SLOT) ? '0 : tail_ff + PTR_BITS'(1);
               cnt_in   = cnt_ff + CNT_BITS'(1);
               bytes_in = byte_sum[BYTES_BITS-1:0];
            end
         end else if (empty) begin
            rsp_data_in.status = STATUS_EMPTY;
         end else begin
            rsp_data_in.status      = STATUS_DELIVERED;
            rsp_data_in.head_handle = head_entry_ff.handle;
            rsp_data_in.head_size   = head_entry_ff.size;
            if (is_deq) begin
               head_in = (head_ff == LAST_SLOT) ? '0 : head_ff + PTR_BITS'(1);
               cnt_in  = cnt_ff - CNT_BITS'(1);
               // saturate at zero
               if (bytes_ff >= BYTES_BITS'(head_entry_ff.size)) begin
                  bytes_in = bytes_ff - BYTES_BITS'(head_entry_ff.size);
               end else begin
                  bytes_in = '0;
               end
            end
         end
         rsp_data_in.packets_held = cnt_in;
         rsp_data_in.bytes_held   = bytes_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         cnt_ff       <= '0;
         bytes_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         cnt_ff       <= cnt_in;
         bytes_ff     <= bytes_in;
         rsp_valid_ff <= cmd.exec;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_empty_no_bytes: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == '0 |-> bytes_ff == '0)
      else $error("bytes held with no packets stored");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= DEPTH_COUNT)
      else $error("packet count beyond queue depth");

   a_deq_decrements: assert property (@(posedge clock) disable iff (reset)
      cmd.exec && is_deq && !empty |=> cnt_ff == $past(cnt_ff) - CNT_BITS'(1))
      else $error("dequeue did not remove one packet");

   a_drop_keeps_state: assert property (@(posedge clock) disable iff (reset)
      cmd.exec && is_enq && drop |=> cnt_ff == $past(cnt_ff) && tail_ff == $past(tail_ff))
      else $error("dropped enqueue changed the queue");
`endif

endmodule

@@ rtl/drop_tail_packet_queue_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drop_tail_packet_queue_top
// FIFO of packet descriptors with tail-drop admission by count or bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive req_data (opcode, handle, size) with start; the
//   beat is taken at a clock edge where start is high and busy is low.
//   Opcodes: enqueue, dequeue, peek (the spare code acts as peek).
//   Result channel: rsp_valid strobes for one cycle with rsp_data (status,
//   head descriptor, packets and bytes held). The receiver cannot stall;
//   every result must be taken in the cycle it is shown.
//   Timing: the accept edge registers the request and the head slot; the
//   execute state resolves them into the result register and strobe. No
//   new beat is taken while executing (busy high), as the descriptor
//   memory's read port is registered: read on accept, resolved in execute.
//   Config: APB-style port, limit_mode at 0x0, max_packets at 0x4,
//   max_bytes at 0x8; write only while no item is in flight.
//   Reset (synchronous): queue empty, limits back to 100 packets and
//   6553500 bytes in packet mode. No clearing pass; accepts right away.
// ----------------------------------------------------------------------------
module drop_tail_packet_queue_top
   import dtq_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_data,
   output logic                 rsp_valid,
   output rsp_type              rsp_data,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [ADDR_BITS-1:0] paddr,
   input  logic [DATA_BITS-1:0] pwdata,
   output logic [DATA_BITS-1:0] prdata,
   output logic                 pready
);

   cfg_type cfg;
   cmd_type cmd;

   dtq_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   dtq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   dtq_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .cfg       (cfg),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drop-tail packet descriptor queue: a command-style driver feeds enqueue,
// dequeue and peek beats from a queue, a shadow copy of the descriptor FIFO
// computes the status and head fields due for each accepted beat, and a
// monitor checks every result strobe against them in order. Limits are
// reprogrammed over the APB port between phases while the queue is idle.
// ----------------------------------------------------------------------------
module testbench;
   import dtq_pkg::*;

   localparam logic [1:0] OP_SPARE    = 2'd3;   // unused code, reads like a peek
   localparam int         CYCLE_LIMIT = 200000;

   logic                 clock   = 1'b0;
   logic                 reset   = 1'b1;
   logic                 start   = 1'b0;
   logic                 busy;
   req_type              req_data = '0;
   logic                 rsp_valid;
   rsp_type              rsp_data;
   logic                 psel    = 1'b0;
   logic                 penable = 1'b0;
   logic                 pwrite  = 1'b0;
   logic [ADDR_BITS-1:0] paddr   = '0;
   logic [DATA_BITS-1:0] pwdata  = '0;
   logic [DATA_BITS-1:0] prdata;
   logic                 pready;

   drop_tail_packet_queue_top u_dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always #1 clock = ~clock;

   // shadow of the descriptor FIFO and its limits
   logic [HANDLE_BITS-1:0] desc_handle [QUEUE_DEPTH];
   logic [SIZE_BITS-1:0]   desc_size   [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]    head_slot    = '0;
   logic [PTR_BITS-1:0]    tail_slot    = '0;
   logic [CNT_BITS-1:0]    held_packets = '0;
   logic [BYTES_BITS-1:0]  held_bytes   = '0;
   logic                   cfg_limit_mode  = 1'b0;
   logic [CNT_BITS-1:0]    cfg_max_packets = RESET_MAX_PACKETS;
   logic [BYTES_BITS-1:0]  cfg_max_bytes   = RESET_MAX_BYTES;

   req_type ops_to_send [$];
   rsp_type results_due [$];
   int      gap_left = 0;
   bit      no_idle  = 1'b0;
   int      errors   = 0;
   int      cycles   = 0;

   function automatic rsp_type queue_op_result(req_type op);
      rsp_type r;
      logic    drop;
      r = '0;
      if (op.opcode == OP_ENQUEUE) begin
         drop = (held_packets >= DEPTH_COUNT)
             || (!cfg_limit_mode && held_packets >= cfg_max_packets)
             || (cfg_limit_mode &&
                 32'(held_bytes) + 32'(op.packet_size) >= 32'(cfg_max_bytes));
         if (drop) begin
            r.status = STATUS_DROPPED;
         end else begin
            desc_handle[tail_slot] = op.packet_handle;
            desc_size[tail_slot]   = op.packet_size;
            tail_slot    = tail_slot + PTR_BITS'(1);
            held_packets = held_packets + CNT_BITS'(1);
            held_bytes   = held_bytes + BYTES_BITS'(op.packet_size);
            r.status     = STATUS_ENQUEUED;
         end
      end else if (held_packets == '0) begin
         r.status = STATUS_EMPTY;
      end else begin
         r.status      = STATUS_DELIVERED;
         r.head_handle = desc_handle[head_slot];
         r.head_size   = desc_size[head_slot];
         if (op.opcode == OP_DEQUEUE) begin
            head_slot    = head_slot + PTR_BITS'(1);
            held_packets = held_packets - CNT_BITS'(1);
            if (held_bytes >= BYTES_BITS'(r.head_size))
               held_bytes = held_bytes - BYTES_BITS'(r.head_size);
            else
               held_bytes = '0;
         end
      end
      r.packets_held = held_packets;
      r.bytes_held   = held_bytes;
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 55)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else
         return $urandom_range(4, 30);
   endfunction

   // driver: one beat per accept, random gaps after each accepted beat
   always @(posedge clock) begin
      if (reset) begin
         start    <= 1'b0;
         gap_left <= 0;
      end else begin
         if (start && !busy)
            results_due.push_back(queue_op_result(req_data));
         if (start && busy) begin
            // hold the beat until taken
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start    <= 1'b0;
         end else if (ops_to_send.size() > 0) begin
            req_data <= ops_to_send.pop_front();
            start    <= 1'b1;
            gap_left <= pick_gap();
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: results come as one-cycle strobes, no back-pressure
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (results_due.size() == 0) begin
            errors++;
            $display("%0t: expected no result, actual %p", $time, rsp_data);
         end else begin
            want = results_due.pop_front();
            if (rsp_data !== want) begin
               errors++;
               $display("%0t: expected %0d %h %h %0d %0d, actual %0d %h %h %0d %0d",
                        $time, want.status, want.head_handle, want.head_size,
                        want.packets_held, want.bytes_held,
                        rsp_data.status, rsp_data.head_handle, rsp_data.head_size,
                        rsp_data.packets_held, rsp_data.bytes_held);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("[drop_tail_packet_queue_top] ERROR");
         $finish;
      end
   end

   function automatic req_type make_op(logic [1:0] code, logic [15:0] handle,
                                       logic [15:0] size);
      req_type op;
      op.opcode        = code;
      op.packet_handle = handle;
      op.packet_size   = size;
      return op;
   endfunction

   task automatic add_random_ops(int count, int enq_pct, bit big_sizes);
      int       r;
      logic [1:0] code;
      logic [15:0] size;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < enq_pct)
            code = OP_ENQUEUE;
         else begin
            r = $urandom_range(0, 9);
            code = (r < 7) ? OP_DEQUEUE : (r < 9) ? OP_PEEK : OP_SPARE;
         end
         r = $urandom_range(0, 15);
         if (r == 0)
            size = 16'h0000;
         else if (r == 1)
            size = 16'hffff;
         else if (r < 4)
            size = 16'($urandom_range(0, 65535));
         else if (big_sizes)
            size = 16'($urandom_range(32768, 65535));
         else
            size = 16'($urandom_range(0, 255));
         ops_to_send.push_back(make_op(code, 16'($urandom_range(0, 65535)), size));
      end
   endtask

   // all beats taken and every result seen: safe to touch the limits
   task automatic wait_idle();
      @(negedge clock);
      while (ops_to_send.size() != 0 || start || results_due.size() != 0)
         @(negedge clock);
   endtask

   task automatic csr_write(logic [1:0] index, logic [31:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_BITS'({index, 2'b00});
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);   // register takes the value here
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (index)
         REG_LIMIT_MODE:  cfg_limit_mode  = value[0];
         REG_MAX_PACKETS: cfg_max_packets = value[CNT_BITS-1:0];
         REG_MAX_BYTES:   cfg_max_bytes   = value[BYTES_BITS-1:0];
         default: ;
      endcase
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // empty queue, extreme descriptors, unused opcode
      ops_to_send.push_back(make_op(OP_PEEK,    16'h0000, 16'h0000));
      ops_to_send.push_back(make_op(OP_DEQUEUE, 16'hffff, 16'hffff));
      ops_to_send.push_back(make_op(OP_SPARE,   16'h0000, 16'h0000));
      ops_to_send.push_back(make_op(OP_ENQUEUE, 16'hffff, 16'hffff));
      ops_to_send.push_back(make_op(OP_ENQUEUE, 16'h0000, 16'h0000));
      ops_to_send.push_back(make_op(OP_PEEK,    16'h0000, 16'h0000));
      ops_to_send.push_back(make_op(OP_SPARE,   16'hffff, 16'hffff));
      ops_to_send.push_back(make_op(OP_DEQUEUE, 16'h0000, 16'h0000));
      ops_to_send.push_back(make_op(OP_DEQUEUE, 16'h0000, 16'h0000));
      ops_to_send.push_back(make_op(OP_DEQUEUE, 16'h0000, 16'h0000));
      ops_to_send.push_back(make_op(OP_ENQUEUE, 16'h1234, 16'h0001));
      wait_idle();

      // zero packet limit drops everything; stored packet stays
      csr_write(REG_MAX_PACKETS, 32'd0);
      ops_to_send.push_back(make_op(OP_ENQUEUE, 16'h5a5a, 16'h00a5));
      ops_to_send.push_back(make_op(OP_PEEK,    16'h0000, 16'h0000));
      ops_to_send.push_back(make_op(OP_DEQUEUE, 16'h0000, 16'h0000));
      wait_idle();

      // byte mode, zero byte limit: even an empty packet is dropped
      csr_write(REG_LIMIT_MODE, 32'd1);
      csr_write(REG_MAX_BYTES, 32'd0);
      ops_to_send.push_back(make_op(OP_ENQUEUE, 16'h00ff, 16'h0000));
      ops_to_send.push_back(make_op(OP_ENQUEUE, 16'hff00, 16'h8000));
      wait_idle();

      // limit of one byte: size 0 fits, size 1 reaches the limit
      csr_write(REG_MAX_BYTES, 32'd1);
      ops_to_send.push_back(make_op(OP_ENQUEUE, 16'hbeef, 16'h0000));
      ops_to_send.push_back(make_op(OP_ENQUEUE, 16'hcafe, 16'h0001));
      ops_to_send.push_back(make_op(OP_DEQUEUE, 16'h0000, 16'h0000));
      wait_idle();

      // packet limit above depth: fill until the store itself is full
      csr_write(REG_LIMIT_MODE, 32'd0);
      csr_write(REG_MAX_PACKETS, 32'd200);
      no_idle = 1'b1;
      add_random_ops(150, 95, 1'b0);
      wait_idle();
      no_idle = 1'b0;
      add_random_ops(100, 20, 1'b1);
      wait_idle();

      // byte mode with a limit of 128 full-size packets, then a tighter one while holding data
      csr_write(REG_LIMIT_MODE, 32'd1);
      csr_write(REG_MAX_BYTES, 32'd8388480);
      add_random_ops(150, 95, 1'b0);
      wait_idle();
      csr_write(REG_MAX_BYTES, $urandom_range(100000, 2000000));
      add_random_ops(120, 55, 1'b1);
      wait_idle();

      // small packet limit, back-to-back beats
      csr_write(REG_LIMIT_MODE, 32'd0);
      csr_write(REG_MAX_PACKETS, 32'd5);
      no_idle = 1'b1;
      add_random_ops(100, 50, 1'b1);
      wait_idle();
      no_idle = 1'b0;

      // packet limit equal to depth
      csr_write(REG_MAX_PACKETS, 32'd128);
      add_random_ops(140, 90, 1'b0);
      wait_idle();

      // back to reset limits, mixed traffic
      csr_write(REG_MAX_PACKETS, 32'(RESET_MAX_PACKETS));
      csr_write(REG_MAX_BYTES, 32'(RESET_MAX_BYTES));
      add_random_ops(160, 50, 1'b1);
      wait_idle();

      // let any stray strobe show up
      repeat (8) @(posedge clock);
      if (errors == 0)
         $display("[drop_tail_packet_queue_top] OK");
      else
         $display("[drop_tail_packet_queue_top] ERROR");
      $finish;
   end

endmodule

@@ drop_tail_packet_queue_top.f @@
rtl/dtq_pkg.sv
rtl/dtq_csr.sv
rtl/dtq_ctrl.sv
rtl/dtq_datapath.sv
rtl/drop_tail_packet_queue_top.sv
sim/testbench.sv
